FILE: sv/tvw_pkg.sv
// Shared widths, register codes, reset values and types of the triangle check pipeline.
package tvw_pkg;

  localparam int FIELD_W      = 48;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int MAX_EDGE_W   = 16;
  localparam int AREA_FLOOR_W = 32;
  localparam int THR_W        = 15;
  localparam int LIM_W        = 2 * MAX_EDGE_W;
  localparam int THR_SQ_W     = 2 * THR_W;
  localparam int AREA4_W      = 2 * AREA_FLOOR_W + 2;
  localparam int CAUSE_W      = 3;
  localparam int WIDE_W       = 128;
  localparam int MUL_CHUNK    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_EDGE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_FLOOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_THR = 2'd2;

  localparam logic [MAX_EDGE_W-1:0]   MAX_EDGE_RST   = 16'd1024;
  localparam logic [AREA_FLOOR_W-1:0] AREA_FLOOR_RST = 32'd0;
  localparam logic [THR_W-1:0]        NORMAL_THR_RST = 15'd4915;
  localparam logic [LIM_W-1:0]        LIM_RST        = 32'd1048576;
  localparam logic [AREA4_W-1:0]      AREA4_RST      = 66'd0;
  localparam logic [THR_SQ_W-1:0]     THR_SQ_RST     = 30'd24157225;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_OK     = 3'd0,
    CAUSE_EDGE   = 3'd1,
    CAUSE_AREA   = 3'd2,
    CAUSE_DEGEN  = 3'd3,
    CAUSE_NORMAL = 3'd4
  } cause_t;

  typedef struct packed {
    logic vld;
    logic edge_long;
  } stg_ctl_t;

endpackage

FILE: sv/tvw_mul.sv
// Two-stage unsigned multiplier built from registered partial products of 32-bit operand chunks.
module tvw_mul #(
  parameter int A_W = 34,
  parameter int B_W = 34,
  parameter int O_W = 68
) (
  input  logic           clk,
  input  logic           en,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic [O_W-1:0] p
);
  import tvw_pkg::*;

  localparam int NA   = (A_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NBC  = (B_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int AP_W = NA * MUL_CHUNK;
  localparam int BP_W = NBC * MUL_CHUNK;
  localparam int S_W  = AP_W + BP_W;
  localparam int PP_W = 2 * MUL_CHUNK;

  logic [AP_W-1:0] a_pad;
  logic [BP_W-1:0] b_pad;
  logic [PP_W-1:0] pp_r [NA*NBC];
  logic [S_W-1:0]  sum;
  logic [O_W-1:0]  p_r;

  assign a_pad = AP_W'(a);
  assign b_pad = BP_W'(b);

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NBC; j++) begin
        sum = sum + (S_W'(pp_r[i*NBC+j]) << (MUL_CHUNK * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NBC; j++) begin
          pp_r[i*NBC+j] <= PP_W'(a_pad[i*MUL_CHUNK +: MUL_CHUNK])
                         * PP_W'(b_pad[j*MUL_CHUNK +: MUL_CHUNK]);
        end
      end
      p_r <= sum[O_W-1:0];
    end
  end

  assign p = p_r;

endmodule

FILE: sv/tvw_geom.sv
// Front stages: edge vectors, edge length test and the face cross product.
module tvw_geom #(
  parameter int POS_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [tvw_pkg::FIELD_W-1:0]     pos_a,
  input  logic [tvw_pkg::FIELD_W-1:0]     pos_b,
  input  logic [tvw_pkg::FIELD_W-1:0]     pos_c,
  input  logic [tvw_pkg::FIELD_W-1:0]     nrm_a,
  input  logic [tvw_pkg::FIELD_W-1:0]     nrm_b,
  input  logic [tvw_pkg::FIELD_W-1:0]     nrm_c,
  input  logic [tvw_pkg::LIM_W-1:0]       lim,
  output tvw_pkg::stg_ctl_t               ctl_o,
  output logic signed [2*POS_BITS+2:0]    c_o [3],
  output logic [tvw_pkg::FIELD_W-1:0]     nrm_o [3]
);
  import tvw_pkg::*;

  localparam int P      = POS_BITS;
  localparam int PAD_W  = 3 * P;
  localparam int DIF_W  = P + 1;
  localparam int PR_W   = 2 * P + 2;
  localparam int ESQ_W  = 2 * P + 1;
  localparam int ES_W   = 2 * P + 2;
  localparam int C_W    = 2 * P + 3;
  localparam int CMP_W  = (ES_W > LIM_W) ? ES_W : LIM_W;

  logic [PAD_W-1:0]        pw [3];
  logic signed [P-1:0]     pc [3][3];
  logic signed [DIF_W-1:0] e_r [3];
  logic signed [DIF_W-1:0] f_r [3];
  logic signed [DIF_W-1:0] g_r [3];
  logic signed [PR_W-1:0]  xp_r [6];
  logic [ESQ_W-1:0]        sq_r [9];
  logic [ES_W-1:0]         es [3];
  logic signed [C_W-1:0]   c_r [3];
  logic [FIELD_W-1:0]      nrm1_r [3];
  logic [FIELD_W-1:0]      nrm2_r [3];
  logic [FIELD_W-1:0]      nrm3_r [3];
  logic                    vld1_r;
  logic                    vld2_r;
  stg_ctl_t                ctl3_r;
  logic                    edge_long_nxt;

  function automatic logic [ESQ_W-1:0] sq_f(input logic signed [DIF_W-1:0] x);
    logic signed [PR_W-1:0] t;
    t = PR_W'(x) * PR_W'(x);
    return t[ESQ_W-1:0];
  endfunction

  always_comb begin
    pw[0] = PAD_W'(pos_a);
    pw[1] = PAD_W'(pos_b);
    pw[2] = PAD_W'(pos_c);
    for (int v = 0; v < 3; v++) begin
      for (int k = 0; k < 3; k++) begin
        pc[v][k] = pw[v][k*P +: P];
      end
    end
  end

  always_comb begin
    edge_long_nxt = 1'b0;
    for (int v = 0; v < 3; v++) begin
      es[v] = ES_W'(sq_r[3*v]) + ES_W'(sq_r[3*v+1]) + ES_W'(sq_r[3*v+2]);
      if (CMP_W'(es[v]) > CMP_W'(lim)) begin
        edge_long_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      ctl3_r <= '0;
    end else if (en) begin
      vld1_r           <= in_vld;
      vld2_r           <= vld1_r;
      ctl3_r.vld       <= vld2_r;
      ctl3_r.edge_long <= edge_long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e_r[k] <= DIF_W'(pc[1][k]) - DIF_W'(pc[0][k]);
        f_r[k] <= DIF_W'(pc[2][k]) - DIF_W'(pc[0][k]);
        g_r[k] <= DIF_W'(pc[2][k]) - DIF_W'(pc[1][k]);
        sq_r[k]   <= sq_f(e_r[k]);
        sq_r[3+k] <= sq_f(g_r[k]);
        sq_r[6+k] <= sq_f(f_r[k]);
      end
      xp_r[0] <= PR_W'(e_r[1]) * PR_W'(f_r[2]);
      xp_r[1] <= PR_W'(e_r[2]) * PR_W'(f_r[1]);
      xp_r[2] <= PR_W'(e_r[2]) * PR_W'(f_r[0]);
      xp_r[3] <= PR_W'(e_r[0]) * PR_W'(f_r[2]);
      xp_r[4] <= PR_W'(e_r[0]) * PR_W'(f_r[1]);
      xp_r[5] <= PR_W'(e_r[1]) * PR_W'(f_r[0]);
      c_r[0]  <= C_W'(xp_r[0]) - C_W'(xp_r[1]);
      c_r[1]  <= C_W'(xp_r[2]) - C_W'(xp_r[3]);
      c_r[2]  <= C_W'(xp_r[4]) - C_W'(xp_r[5]);
      nrm1_r[0] <= nrm_a;
      nrm1_r[1] <= nrm_b;
      nrm1_r[2] <= nrm_c;
      nrm2_r    <= nrm1_r;
      nrm3_r    <= nrm2_r;
    end
  end

  assign ctl_o = ctl3_r;
  assign c_o   = c_r;
  assign nrm_o = nrm3_r;

endmodule

FILE: sv/tvw_dotsq.sv
// Middle stages: squared cross length and the cross product dotted with each vertex normal.
module tvw_dotsq #(
  parameter int POS_BITS         = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          en,
  input  tvw_pkg::stg_ctl_t                             ctl_i,
  input  logic signed [2*POS_BITS+2:0]                  c_i [3],
  input  logic [tvw_pkg::FIELD_W-1:0]                   nrm_i [3],
  output tvw_pkg::stg_ctl_t                             ctl_o,
  output logic [4*POS_BITS+3:0]                         cc_o,
  output logic signed [2*POS_BITS+NORMAL_FRAC_BITS+4:0] d_o [3]
);
  import tvw_pkg::*;

  localparam int P      = POS_BITS;
  localparam int NB     = NORMAL_FRAC_BITS + 2;
  localparam int NPAD_W = 3 * NB;
  localparam int C_W    = 2 * P + 3;
  localparam int CM_W   = 2 * P + 2;
  localparam int CC_W   = 4 * P + 4;
  localparam int D_W    = C_W + NB;

  logic [NPAD_W-1:0]      nw [3];
  logic signed [NB-1:0]   nc [3][3];
  logic signed [C_W-1:0]  cn [3];
  logic [CM_W-1:0]        cm [3];
  logic [CC_W-1:0]        csq [3];
  logic signed [D_W-1:0]  dp_r [9];
  logic signed [D_W-1:0]  ds_r [3];
  logic signed [D_W-1:0]  d_r [3];
  logic [CC_W-1:0]        cc_r;
  stg_ctl_t               ctl4_r;
  stg_ctl_t               ctl5_r;
  stg_ctl_t               ctl6_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nw[i] = NPAD_W'(nrm_i[i]);
      for (int k = 0; k < 3; k++) begin
        nc[i][k] = nw[i][k*NB +: NB];
      end
    end
    for (int k = 0; k < 3; k++) begin
      cn[k] = -c_i[k];
      cm[k] = c_i[k][C_W-1] ? cn[k][CM_W-1:0] : c_i[k][CM_W-1:0];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_csq
    tvw_mul #(
      .A_W(CM_W),
      .B_W(CM_W),
      .O_W(CC_W)
    ) u_csq (
      .clk(clk),
      .en (en),
      .a  (cm[k]),
      .b  (cm[k]),
      .p  (csq[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
    end else if (en) begin
      ctl4_r <= ctl_i;
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          dp_r[3*i+k] <= D_W'(c_i[k]) * D_W'(nc[i][k]);
        end
        ds_r[i] <= dp_r[3*i] + dp_r[3*i+1] + dp_r[3*i+2];
      end
      d_r  <= ds_r;
      cc_r <= csq[0] + csq[1] + csq[2];
    end
  end

  assign ctl_o = ctl6_r;
  assign cc_o  = cc_r;
  assign d_o   = d_r;

endmodule

FILE: sv/triangle_validity_and_winding.sv
// Top level of the triangle degeneracy and orientation check.
// Nine register stages lie between an accepted request and its offered result.
// One request is accepted every cycle; the whole pipeline holds while the output is not taken.
// Reset clears the stage valid bits and loads max_edge 1024, the minimum area 0 and
// normal_thr 4915.
// Derived squares of the registers are refreshed in the cycle after a configuration write.
module triangle_validity_and_winding #(
  parameter int POS_BITS         = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tvw_pkg::FIELD_W-1:0]      in_pos_a,
  input  logic [tvw_pkg::FIELD_W-1:0]      in_pos_b,
  input  logic [tvw_pkg::FIELD_W-1:0]      in_pos_c,
  input  logic [tvw_pkg::FIELD_W-1:0]      in_nrm_a,
  input  logic [tvw_pkg::FIELD_W-1:0]      in_nrm_b,
  input  logic [tvw_pkg::FIELD_W-1:0]      in_nrm_c,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_valid_res,
  output logic [tvw_pkg::CAUSE_W-1:0]      out_reject_cause,
  output logic                             out_swap_winding,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tvw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tvw_pkg::CFG_DATA_W-1:0]   cfg_value
);
  import tvw_pkg::*;

  localparam int P     = POS_BITS;
  localparam int NF    = NORMAL_FRAC_BITS;
  localparam int C_W   = 2 * P + 3;
  localparam int CC_W  = 4 * P + 4;
  localparam int D_W   = 2 * P + NF + 5;
  localparam int DU_W  = D_W - 1;
  localparam int LO_W  = (DU_W > 64) ? 64 : DU_W;
  localparam int SQ_W  = (DU_W + LO_W > WIDE_W) ? WIDE_W : DU_W + LO_W;
  localparam int TC_W  = (CC_W + THR_SQ_W > WIDE_W) ? WIDE_W : CC_W + THR_SQ_W;
  localparam int AC_W  = (CC_W > AREA4_W) ? CC_W : AREA4_W;
  localparam int A2_W  = 2 * AREA_FLOOR_W;

  typedef struct packed {
    logic       vld;
    logic       edge_long;
    logic       area_small;
    logic       degen;
    logic [2:0] neg;
  } tail_t;

  logic [MAX_EDGE_W-1:0]   max_edge_r;
  logic [AREA_FLOOR_W-1:0] area_floor_r;
  logic [THR_W-1:0]        normal_thr_r;
  logic [LIM_W-1:0]        lim_r;
  logic [AREA4_W-1:0]      area4_r;
  logic [THR_SQ_W-1:0]     thr_sq_r;

  logic                   adv;
  stg_ctl_t               ctl3;
  stg_ctl_t               ctl6;
  logic signed [C_W-1:0]  cx [3];
  logic [FIELD_W-1:0]     nrm3 [3];
  logic [CC_W-1:0]        cc;
  logic signed [D_W-1:0]  d [3];
  logic [TC_W-1:0]        tc;
  logic [SQ_W-1:0]        sq [3];

  tail_t                  t7_nxt;
  tail_t                  t7_r;
  tail_t                  t8_r;
  logic [2:0]             low;
  cause_t                 cause_nxt;
  logic                   out_valid_r;
  cause_t                 out_cause_r;
  logic                   out_res_r;
  logic                   out_swap_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_edge_r   <= MAX_EDGE_RST;
      area_floor_r <= AREA_FLOOR_RST;
      normal_thr_r <= NORMAL_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_EDGE:   max_edge_r   <= cfg_value[MAX_EDGE_W-1:0];
        REG_AREA_FLOOR: area_floor_r <= cfg_value[AREA_FLOOR_W-1:0];
        REG_NORMAL_THR: normal_thr_r <= cfg_value[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r    <= LIM_RST;
      area4_r  <= AREA4_RST;
      thr_sq_r <= THR_SQ_RST;
    end else begin
      lim_r    <= LIM_W'(max_edge_r) * LIM_W'(max_edge_r);
      area4_r  <= {A2_W'(area_floor_r) * A2_W'(area_floor_r), 2'b00};
      thr_sq_r <= THR_SQ_W'(normal_thr_r) * THR_SQ_W'(normal_thr_r);
    end
  end

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  tvw_geom #(
    .POS_BITS(POS_BITS)
  ) u_geom (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .in_vld(in_valid),
    .pos_a (in_pos_a),
    .pos_b (in_pos_b),
    .pos_c (in_pos_c),
    .nrm_a (in_nrm_a),
    .nrm_b (in_nrm_b),
    .nrm_c (in_nrm_c),
    .lim   (lim_r),
    .ctl_o (ctl3),
    .c_o   (cx),
    .nrm_o (nrm3)
  );

  tvw_dotsq #(
    .POS_BITS        (POS_BITS),
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_dotsq (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (adv),
    .ctl_i(ctl3),
    .c_i  (cx),
    .nrm_i(nrm3),
    .ctl_o(ctl6),
    .cc_o (cc),
    .d_o  (d)
  );

  tvw_mul #(
    .A_W(CC_W),
    .B_W(THR_SQ_W),
    .O_W(TC_W)
  ) u_tc (
    .clk(clk),
    .en (adv),
    .a  (cc),
    .b  (thr_sq_r),
    .p  (tc)
  );

  for (genvar i = 0; i < 3; i++) begin : g_sq
    tvw_mul #(
      .A_W(DU_W),
      .B_W(LO_W),
      .O_W(SQ_W)
    ) u_sq (
      .clk(clk),
      .en (adv),
      .a  (d[i][DU_W-1:0]),
      .b  (d[i][LO_W-1:0]),
      .p  (sq[i])
    );
  end

  always_comb begin
    t7_nxt.vld        = ctl6.vld;
    t7_nxt.edge_long  = ctl6.edge_long;
    t7_nxt.area_small = AC_W'(cc) < AC_W'(area4_r);
    t7_nxt.degen      = (cc == '0);
    for (int i = 0; i < 3; i++) begin
      t7_nxt.neg[i] = d[i][D_W-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      low[i] = t8_r.neg[i] || (WIDE_W'(sq[i]) < WIDE_W'(tc));
    end
    if (t8_r.edge_long) begin
      cause_nxt = CAUSE_EDGE;
    end else if (t8_r.area_small) begin
      cause_nxt = CAUSE_AREA;
    end else if (t8_r.degen) begin
      cause_nxt = CAUSE_DEGEN;
    end else if (&low) begin
      cause_nxt = CAUSE_NORMAL;
    end else begin
      cause_nxt = CAUSE_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t7_r        <= '0;
      t8_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      t7_r        <= t7_nxt;
      t8_r        <= t7_r;
      out_valid_r <= t8_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cause_r <= cause_nxt;
      out_res_r   <= (cause_nxt == CAUSE_OK);
      out_swap_r  <= t8_r.neg[0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_valid_res    = out_res_r;
  assign out_reject_cause = out_cause_r;
  assign out_swap_winding = out_swap_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable({t7_r.vld, t8_r.vld, out_valid_r}))
    else $error("pipeline valid bits moved during a stall");

  a_res_matches_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_res == (out_reject_cause == CAUSE_OK)))
    else $error("valid_res disagrees with reject_cause");

  a_degen_no_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reject_cause == CAUSE_DEGEN) |-> !out_swap_winding)
    else $error("degenerate triangle flagged for a winding swap");

  a_edge_first: assert property (@(posedge clk) disable iff (!rst_n)
    (t8_r.vld && t8_r.edge_long && in_ready) |=> (out_reject_cause == CAUSE_EDGE))
    else $error("long edge not reported first");

endmodule

FILE: tb/triangle_validity_and_winding_test.sv
// Self-checking testbench for the triangle validity and winding pipeline.
module triangle_validity_and_winding_test;
  import tvw_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 34;
  localparam int PAUSE_CYCLES = 12;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [FIELD_W-1:0] pos_a, pos_b, pos_c, nrm_a, nrm_b, nrm_c;
  } triangle_t;

  typedef struct packed {
    logic valid_res;
    cause_t cause;
    logic swap;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  triangle_t in_tri = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_valid_res;
  logic [CAUSE_W-1:0] out_reject_cause;
  logic out_swap_winding;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_value = '0;

  logic [MAX_EDGE_W-1:0] set_max_edge = MAX_EDGE_RST;
  logic [AREA_FLOOR_W-1:0] set_area_floor = AREA_FLOOR_RST;
  logic [THR_W-1:0] set_thr = NORMAL_THR_RST;

  triangle_t pending[$];
  verdict_t verdicts[$];
  verdict_t want;
  int n_accepted = 0;
  int n_checked = 0;
  int err_count = 0;
  int cycle_count = 0;
  int cause_seen[0:4] = '{default: 0};
  int swap_seen = 0;
  logic quiet;

  assign quiet = (n_accepted >= 300) && (n_accepted < 450);

  triangle_validity_and_winding dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_a         (in_tri.pos_a),
    .in_pos_b         (in_tri.pos_b),
    .in_pos_c         (in_tri.pos_c),
    .in_nrm_a         (in_tri.nrm_a),
    .in_nrm_b         (in_tri.nrm_b),
    .in_nrm_c         (in_tri.nrm_c),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valid_res    (out_valid_res),
    .out_reject_cause (out_reject_cause),
    .out_swap_winding (out_swap_winding),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_value        (cfg_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic verdict_t judge_triangle(triangle_t t);
    logic [FIELD_W-1:0] words[6];
    longint p[3][3];
    logic signed [WIDE_W-1:0] nv[3][3];
    longint e[3], f[3];
    longint s, lim;
    logic signed [WIDE_W-1:0] cr[3], dp[3];
    logic [WIDE_W-1:0] cc, area4, tc, thr_w, area_w;
    logic edge_long, all_low;
    verdict_t v;
    words = '{t.pos_a, t.pos_b, t.pos_c, t.nrm_a, t.nrm_b, t.nrm_c};
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        p[i][k] = longint'($signed(words[i][16*k +: 16]));
        nv[i][k] = $signed(words[3+i][16*k +: 16]);
      end
    end
    lim = longint'(set_max_edge) * longint'(set_max_edge);
    edge_long = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s = 0;
      for (int k = 0; k < 3; k++) begin
        s += (p[i][k] - p[(i+1)%3][k]) * (p[i][k] - p[(i+1)%3][k]);
      end
      if (s > lim) begin
        edge_long = 1'b1;
      end
    end
    for (int k = 0; k < 3; k++) begin
      e[k] = p[1][k] - p[0][k];
      f[k] = p[2][k] - p[0][k];
    end
    cr[0] = e[1] * f[2] - e[2] * f[1];
    cr[1] = e[2] * f[0] - e[0] * f[2];
    cr[2] = e[0] * f[1] - e[1] * f[0];
    cc = cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2];
    area_w = set_area_floor;
    area4 = (area_w * area_w) << 2;
    thr_w = set_thr;
    tc = cc * thr_w * thr_w;
    all_low = 1'b1;
    for (int i = 0; i < 3; i++) begin
      dp[i] = cr[0] * nv[i][0] + cr[1] * nv[i][1] + cr[2] * nv[i][2];
      if (dp[i] >= 0 && $unsigned(dp[i] * dp[i]) >= tc) begin
        all_low = 1'b0;
      end
    end
    if (edge_long) begin
      v.cause = CAUSE_EDGE;
    end else if (cc < area4) begin
      v.cause = CAUSE_AREA;
    end else if (cc == 0) begin
      v.cause = CAUSE_DEGEN;
    end else if (all_low) begin
      v.cause = CAUSE_NORMAL;
    end else begin
      v.cause = CAUSE_OK;
    end
    v.valid_res = (v.cause == CAUSE_OK);
    v.swap = (dp[0] < 0);
    return v;
  endfunction

  function automatic logic [FIELD_W-1:0] pack3(int x, int y, int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  function automatic logic [FIELD_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[FIELD_W-1:0];
  endfunction

  function automatic int srand(int m);
    return int'($urandom_range(2 * m)) - m;
  endfunction

  function automatic int clamp16(real v);
    if (v > 32767.0) begin
      return 32767;
    end else if (v < -32768.0) begin
      return -32768;
    end
    return int'(v);
  endfunction

  function automatic triangle_t gen_triangle(int span);
    triangle_t t;
    int a[3], e[3], f[3], n[3][3];
    real r[3];
    real len, sc;
    int roll, lim_a, k, na;
    logic flip_all, flip;
    roll = $urandom_range(99);
    if (roll < 15) begin
      t = {rand48(), rand48(), rand48(), rand48(), rand48(), rand48()};
      return t;
    end
    lim_a = (span < 32000) ? 32000 - span : 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = srand(lim_a);
      e[i] = srand(span);
      f[i] = srand(span);
    end
    if (roll < 27) begin
      k = srand(2);
      for (int i = 0; i < 3; i++) begin
        if (roll < 22) begin
          f[i] = e[i] * k;
        end else begin
          e[i] = 0;
        end
      end
    end
    t.pos_a = pack3(a[0], a[1], a[2]);
    t.pos_b = pack3(a[0] + e[0], a[1] + e[1], a[2] + e[2]);
    t.pos_c = pack3(a[0] + f[0], a[1] + f[1], a[2] + f[2]);
    r[0] = real'(e[1]) * f[2] - real'(e[2]) * f[1];
    r[1] = real'(e[2]) * f[0] - real'(e[0]) * f[2];
    r[2] = real'(e[0]) * f[1] - real'(e[1]) * f[0];
    len = $sqrt(r[0] * r[0] + r[1] * r[1] + r[2] * r[2]);
    if (len == 0.0) begin
      t.nrm_a = rand48();
      t.nrm_b = rand48();
      t.nrm_c = rand48();
      return t;
    end
    na = $urandom_range(1) ? 2000 : 12000;
    flip_all = ($urandom_range(9) == 0);
    for (int i = 0; i < 3; i++) begin
      flip = flip_all || (i == 0 && $urandom_range(4) == 0);
      sc = (flip ? -16384.0 : 16384.0) / len;
      for (int j = 0; j < 3; j++) begin
        n[i][j] = clamp16(r[j] * sc + srand(na));
      end
    end
    t.nrm_a = pack3(n[0][0], n[0][1], n[0][2]);
    t.nrm_b = pack3(n[1][0], n[1][1], n[1][2]);
    t.nrm_c = pack3(n[2][0], n[2][1], n[2][2]);
    return t;
  endfunction

  task automatic report_field(string name, int expv, int actv);
    err_count++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expv, actv);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        in_tri <= pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // A request is predicted when it is accepted and its verdict queued.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none actual %0b/%0d/%0b", $time,
                   out_valid_res, out_reject_cause, out_swap_winding);
        end else begin
          want = verdicts.pop_front();
          n_checked++;
          cause_seen[want.cause]++;
          if (want.swap) begin
            swap_seen++;
          end
          if (want.valid_res !== out_valid_res) begin
            report_field("valid_res", want.valid_res, out_valid_res);
          end
          if (want.cause !== out_reject_cause) begin
            report_field("reject_cause", want.cause, out_reject_cause);
          end
          if (want.swap !== out_swap_winding) begin
            report_field("swap_winding", want.swap, out_swap_winding);
          end
        end
      end
      if (in_valid && in_ready) begin
        verdicts.insert(verdicts.size(), judge_triangle(in_tri));
        n_accepted <= n_accepted + 1;
      end
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic drain();
    do @(negedge clk); while (pending.size() != 0 || in_valid || verdicts.size() != 0);
    repeat (PAUSE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_value <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MAX_EDGE: begin
        set_max_edge = value[MAX_EDGE_W-1:0];
      end
      REG_AREA_FLOOR: begin
        set_area_floor = value[AREA_FLOOR_W-1:0];
      end
      REG_NORMAL_THR: begin
        set_thr = value[THR_W-1:0];
      end
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(logic [CFG_DATA_W-1:0] max_edge,
                               logic [CFG_DATA_W-1:0] area_floor,
                               logic [CFG_DATA_W-1:0] thr);
    write_reg(REG_MAX_EDGE, max_edge);
    write_reg(REG_AREA_FLOOR, area_floor);
    write_reg(REG_NORMAL_THR, thr);
    repeat (3) @(negedge clk);
  endtask

  task automatic add_tri(logic [FIELD_W-1:0] pa, logic [FIELD_W-1:0] pb,
                         logic [FIELD_W-1:0] pc, logic [FIELD_W-1:0] na,
                         logic [FIELD_W-1:0] nb, logic [FIELD_W-1:0] nc);
    pending.insert(pending.size(), {pa, pb, pc, na, nb, nc});
  endtask

  task automatic add_random(int count, int span);
    repeat (count) pending.insert(pending.size(), gen_triangle(span));
  endtask

  initial begin
    logic [FIELD_W-1:0] o, px, py, nz, ngz;
    o = pack3(0, 0, 0);
    px = pack3(100, 0, 0);
    py = pack3(0, 100, 0);
    nz = pack3(0, 0, 16384);
    ngz = pack3(0, 0, -16384);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_tri(o, px, py, nz, nz, nz);
    add_tri(o, px, py, ngz, ngz, ngz);
    add_tri(o, px, py, ngz, nz, nz);
    add_tri(o, px, py, ngz, ngz, nz);
    add_tri(pack3(5, -7, 9), pack3(5, -7, 9), pack3(5, -7, 9), nz, nz, nz);
    add_tri(o, pack3(10, 10, 10), pack3(20, 20, 20), nz, nz, nz);
    add_tri(o, o, py, nz, nz, nz);
    add_tri(o, pack3(1025, 0, 0), py, nz, nz, nz);
    add_tri(o, pack3(1024, 0, 0), pack3(512, 512, 0), nz, nz, nz);
    add_tri(pack3(-32768, -32768, -32768), pack3(32767, 32767, 32767), o, nz, nz, nz);
    add_tri(pack3(32767, 32767, 32767), pack3(32267, 32767, 32767),
            pack3(32767, 32267, 32767), nz, nz, nz);
    add_tri(pack3(-32768, -32768, -32768), pack3(-32268, -32768, -32768),
            pack3(-32768, -32268, -32768), nz, nz, nz);
    add_tri(o, px, py, pack3(16384, 0, 4915), pack3(16384, 0, 4915), pack3(16384, 0, 4915));
    add_tri(o, px, py, pack3(16384, 0, 4914), pack3(16384, 0, 4914), pack3(16384, 0, 4914));
    add_tri(o, px, py, pack3(0, 0, 1), pack3(0, 0, 1), pack3(0, 0, 1));
    add_tri(o, px, py, pack3(-32768, -32768, 32767), pack3(32767, 32767, 32767),
            pack3(-32768, 32767, -32768));
    add_tri(o, px, py, pack3(16384, 0, 0), pack3(0, 16384, 0), pack3(16384, 16384, 0));
    add_tri(o, px, py, ngz, pack3(0, 0, 4914), pack3(0, 0, 4914));
    add_tri('0, '0, '0, '0, '0, '0);
    add_tri('1, '1, '1, '1, '1, '1);
    add_random(150, 500);
    drain();

    apply_setting(32'd65535, 32'd0, 32'd16384);
    @(negedge clk);
    add_random(100, 8000);
    drain();

    apply_setting(32'd0, 32'd0, 32'd0);
    add_random(60, 3);
    drain();

    apply_setting(32'hABCD_07D0, 32'd5000, 32'hFFFF_FFFF);
    add_tri(o, px, py, nz, nz, nz);
    add_tri(o, px, pack3(0, 99, 0), nz, nz, nz);
    add_random(120, 300);
    drain();

    apply_setting(32'd1024, 32'hFFFF_FFFF, 32'd4915);
    add_random(60, 400);
    drain();

    apply_setting(32'd300, 32'd100, 32'd12000);
    write_reg(REG_UNUSED, 32'h0000_0005);
    repeat (3) @(negedge clk);
    add_random(120, 150);
    drain();

    apply_setting(32'd65535, 32'd1, 32'd4915);
    add_random(150, 20000);
    drain();

    $display("Checked %0d verdicts over seven register settings, extremes included.",
             n_checked);
    $display("Causes ok/edge/area/degenerate/normals %0d/%0d/%0d/%0d/%0d, swaps %0d.",
             cause_seen[0], cause_seen[1], cause_seen[2], cause_seen[3], cause_seen[4],
             swap_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
